// File: rtl/vna_pkg.sv
package vna_pkg;

    localparam int VertexCount = 1024;
    localparam int IdxBits     = 10;
    localparam int PosBits     = 16;
    localparam int SumBits     = 48;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_TRI  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [9:0]          vertex_index;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic signed [15:0]  pos_z;
        logic [9:0]          corner_a;
        logic [9:0]          corner_b;
        logic [9:0]          corner_c;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0]  normal_x;
        logic signed [15:0]  normal_y;
        logic signed [15:0]  normal_z;
        logic                is_degenerate;
    } out_item_t;

endpackage

// File: rtl/vna_divider.sv
// Restoring divider, one quotient bit per cycle: q = num / den.
module vna_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [45:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [45:0] quo
);
    logic [45:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [33:0] diff;

    always_comb
    begin
        trial     = {rem_reg, q_reg[45]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = 6'd46;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next = diff[31:0];
                q_next   = {q_reg[44:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[44:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign quo = q_next;
endmodule

// File: rtl/vertex_normal_accumulator_top.sv
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | in_item_t
// out     | out | out_valid / out_ready| out_item_t
// Triangle: three position reads, six passes on the shared multiplier, three
// read-modify-writes. Read: a bit-serial square root and three divides; a zero
// sum skips both.
// Reset clears control only; memories are undefined until loaded.
// in_ready is high only when idle; a finished read holds until the output register is free.
module vertex_normal_accumulator_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vna_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vna_pkg::out_item_t   out_data
);
    import vna_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_LOAD  = 16'h0002,
        S_RDA   = 16'h0004,
        S_RDB   = 16'h0008,
        S_RDC   = 16'h0010,
        S_MUL   = 16'h0020,
        S_SRD   = 16'h0040,
        S_ACC   = 16'h0080,
        S_RSUM  = 16'h0100,
        S_MAG   = 16'h0200,
        S_SQ    = 16'h0400,
        S_SQRT  = 16'h0800,
        S_DIV   = 16'h1000,
        S_DWAIT = 16'h2000,
        S_OUT   = 16'h4000,
        S_WAIT  = 16'h8000
    } state_t;

    logic [47:0] pos_mem [VertexCount];
    logic [SumBits*3-1:0] sum_mem [VertexCount];

    state_t      st_reg, st_next;
    in_item_t    it_reg;
    logic [47:0] pos_q;
    logic [SumBits*3-1:0] sum_q;
    logic [IdxBits-1:0] raddr;
    logic        sum_rd;
    logic [IdxBits-1:0] waddr;
    logic        sum_we;
    logic [SumBits*3-1:0] sum_wd;

    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [15:0] pa_reg [3];
    logic signed [SumBits-1:0] n_reg [3];
    logic [3:0]  step_reg;
    logic signed [33:0] prod;
    logic signed [16:0] ma, mb;

    logic [SumBits-1:0] s_reg [3];
    logic [31:0] t_reg [3];
    logic [63:0] sq_x_reg;
    logic [31:0] sq_r_reg;
    logic [31:0] sq_bit_reg;
    logic        div_start, div_done;
    logic [45:0] div_quo;
    logic [1:0]  ci_reg;
    logic [15:0] nq_reg [3];
    out_item_t   out_reg;
    logic        ov_reg;
    logic        out_free;

    function automatic logic [SumBits-1:0] mag_of(input logic [SumBits-1:0] v);
        mag_of = v[SumBits-1] ? (~v + 1'b1) : v;
    endfunction

    assign in_ready  = (st_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    // output register is free, or its beat goes this cycle
    assign out_free  = !ov_reg || out_ready;

    // shared multiplier
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    begin ma = e1_reg[1]; mb = e2_reg[2]; end
            2'd1:    begin ma = e1_reg[2]; mb = e2_reg[0]; end
            default: begin ma = e1_reg[0]; mb = e2_reg[1]; end
        endcase
        if (step_reg[2])
        begin
            unique case (step_reg[1:0])
                2'd0:    begin ma = e1_reg[2]; mb = e2_reg[1]; end
                2'd1:    begin ma = e1_reg[0]; mb = e2_reg[2]; end
                default: begin ma = e1_reg[1]; mb = e2_reg[0]; end
            endcase
        end
        prod = ma * mb;
    end

    always_comb
    begin
        raddr = it_reg.vertex_index;
        if (st_reg == S_IDLE)
            raddr = in_data.corner_a;
        else if (st_reg == S_RDA)
            raddr = it_reg.corner_b;
        else if (st_reg == S_RDB)
            raddr = it_reg.corner_c;
        else if (st_reg == S_SRD || st_reg == S_ACC)
        begin
            unique case (step_reg[1:0])
                2'd0:    raddr = it_reg.corner_a;
                2'd1:    raddr = it_reg.corner_b;
                default: raddr = it_reg.corner_c;
            endcase
        end
        sum_rd = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[waddr] <= sum_wd;
        if (st_reg == S_LOAD)
            pos_mem[it_reg.vertex_index] <= {it_reg.pos_x, it_reg.pos_y, it_reg.pos_z};
        pos_q <= pos_mem[raddr];
        if (sum_rd)
            sum_q <= sum_mem[(st_reg == S_IDLE) ? in_data.vertex_index : raddr];
    end

    always_comb
    begin
        sum_we = 1'b0;
        waddr  = raddr;
        sum_wd = {sum_q[143:96] + n_reg[0], sum_q[95:48] + n_reg[1],
                  sum_q[47:0] + n_reg[2]};
        if (st_reg == S_LOAD)
        begin
            sum_we = 1'b1;
            waddr  = it_reg.vertex_index;
            sum_wd = '0;
        end
        else if (st_reg == S_ACC)
            sum_we = 1'b1;
    end

    vna_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({t_reg[ci_reg], 14'd0} + {15'd0, sq_r_reg[31:1]}),
        .den   (sq_r_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign div_start = (st_reg == S_DIV);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    unique case (in_data.kind)
                        KIND_LOAD: st_next = S_LOAD;
                        KIND_TRI:  st_next = S_RDA;
                        KIND_READ: st_next = S_RSUM;
                        default:   st_next = S_IDLE;
                    endcase
                end
            S_LOAD:  st_next = S_IDLE;
            S_RDA:   st_next = S_RDB;
            S_RDB:   st_next = S_RDC;
            S_RDC:   st_next = S_MUL;
            S_MUL:   if (step_reg == 4'd6) st_next = S_SRD;
            S_SRD:   st_next = S_ACC;
            S_ACC:   st_next = (step_reg[1:0] == 2'd2) ? S_IDLE : S_SRD;
            S_RSUM:  st_next = S_MAG;
            S_MAG:   st_next = (s_reg[0] == '0 && s_reg[1] == '0 && s_reg[2] == '0)
                               ? S_OUT : S_SQ;
            S_SQ:    if (step_reg == 4'd2) st_next = S_SQRT;
            S_SQRT:  if (sq_bit_reg == 32'd0) st_next = S_DIV;
            S_DIV:   st_next = S_DWAIT;
            S_DWAIT: if (div_done) st_next = (ci_reg == 2'd2) ? S_OUT : S_DIV;
            S_OUT:   if (out_free) st_next = S_WAIT;
            S_WAIT:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_OUT && out_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    logic [SumBits-1:0] mg [3];
    logic [SumBits-1:0] mx;
    logic [6:0]  kk;
    logic [31:0] sq_try;
    logic [31:0] sq_op;
    logic [63:0] sq_prod;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mg[i] = mag_of(s_reg[i]);
        mx = mg[0];
        if (mg[1] > mx) mx = mg[1];
        if (mg[2] > mx) mx = mg[2];
        kk = '0;
        for (int j = 18; j >= 1; j--)
            if (mx[29 + j] && kk == '0) kk = 7'(j);
        sq_try = sq_r_reg | sq_bit_reg;
        // one squarer for the length sum and the root trials
        sq_op   = (st_reg == S_SQRT) ? sq_try : t_reg[step_reg[1:0]];
        sq_prod = 64'(sq_op) * 64'(sq_op);
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                it_reg   <= in_data;
                step_reg <= '0;
            end
            S_RDA:
            begin
                pa_reg[0] <= pos_q[47:32];
                pa_reg[1] <= pos_q[31:16];
                pa_reg[2] <= pos_q[15:0];
            end
            S_RDB:
            begin
                e1_reg[0] <= 17'(signed'(pos_q[47:32])) - 17'(pa_reg[0]);
                e1_reg[1] <= 17'(signed'(pos_q[31:16])) - 17'(pa_reg[1]);
                e1_reg[2] <= 17'(signed'(pos_q[15:0])) - 17'(pa_reg[2]);
            end
            S_RDC:
            begin
                e2_reg[0] <= 17'(signed'(pos_q[47:32])) - 17'(pa_reg[0]);
                e2_reg[1] <= 17'(signed'(pos_q[31:16])) - 17'(pa_reg[1]);
                e2_reg[2] <= 17'(signed'(pos_q[15:0])) - 17'(pa_reg[2]);
            end
            S_MUL:
            begin
                // steps 0-2 load the first products, 4-6 subtract the second
                if (!step_reg[2])
                    n_reg[step_reg[1:0]] <= SumBits'(prod);
                else
                    n_reg[step_reg[1:0]] <= n_reg[step_reg[1:0]] - SumBits'(prod);
                unique case (step_reg)
                    4'd2:    step_reg <= 4'd4;
                    4'd6:    step_reg <= 4'd0;
                    default: step_reg <= step_reg + 4'd1;
                endcase
            end
            S_ACC:
                step_reg <= step_reg + 4'd1;
            S_RSUM:
            begin
                s_reg[0] <= sum_q[143:96];
                s_reg[1] <= sum_q[95:48];
                s_reg[2] <= sum_q[47:0];
            end
            S_MAG:
            begin
                for (int i = 0; i < 3; i++)
                    t_reg[i] <= 32'(mg[i] >> kk);
                sq_x_reg <= '0;
                step_reg <= '0;
                ci_reg   <= '0;
            end
            S_SQ:
            begin
                sq_x_reg   <= sq_x_reg + sq_prod;
                step_reg   <= step_reg + 4'd1;
                sq_r_reg   <= '0;
                sq_bit_reg <= 32'h8000_0000;
            end
            S_SQRT:
            begin
                if (sq_prod <= sq_x_reg)
                    sq_r_reg <= sq_try;
                sq_bit_reg <= sq_bit_reg >> 1;
            end
            S_DWAIT:
                if (div_done)
                begin
                    nq_reg[ci_reg] <= s_reg[ci_reg][SumBits-1] ? 16'(-div_quo)
                                                               : 16'(div_quo);
                    ci_reg <= ci_reg + 2'd1;
                end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (s_reg[0] == '0 && s_reg[1] == '0 && s_reg[2] == '0)
                        out_reg <= '{16'sd0, 16'sd0, 16'sd0, 1'b1};
                    else
                        out_reg <= '{nq_reg[0], nq_reg[1], nq_reg[2], 1'b0};
                end
            end
            default: ;
        endcase
    end
endmodule
